@@ rtl/core/msrc_pkg.sv @@
package msrc_pkg;

  // CRC-16 Modbus: all-ones seed, reflected polynomial, no final XOR
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame layout (byte positions within the 9-byte response)
  localparam logic [3:0] IDX_FUNC     = 4'd1;
  localparam logic [3:0] IDX_DATA_LO  = 4'd3;
  localparam logic [3:0] IDX_DATA_HI  = 4'd6;
  localparam logic [3:0] IDX_CRC_LO   = 4'd7;
  localparam logic [3:0] CRC_SPAN     = 4'd7;
  localparam logic [3:0] FRAME_LAST   = 4'd8;

  localparam logic [7:0] FUNC_RESET   = 8'h04;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        reading_valid;
    logic [15:0] temperature_centi;
    logic [15:0] humidity_centi;
  } result_t;

  // One byte through the CRC: eight bit steps, unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/msrc_frame.sv @@
module msrc_frame (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_data,
  input  logic                    acc,
  input  logic                    func,
  input  logic [7:0]              rx_byte,
  output logic                    res_valid,
  output msrc_pkg::result_t       res
);

  logic [7:0]  exp_func_r,  exp_func_nxt;
  logic [3:0]  byte_idx_r,  byte_idx_nxt;
  logic [15:0] crc_r,       crc_nxt;
  logic [7:0]  func_seen_r, func_seen_nxt;
  logic [31:0] data_r,      data_nxt;
  logic [7:0]  crc_lo_r,    crc_lo_nxt;
  logic [15:0] temp_r,      temp_nxt;
  logic [15:0] humi_r,      humi_nxt;
  logic        last_ok_r,   last_ok_nxt;
  logic [1:0]  status;
  logic [15:0] crc_step;

  assign crc_step = msrc_pkg::crc_byte(crc_r, rx_byte);

  // Frame tracking and end-of-frame check
  always_comb begin
    exp_func_nxt  = cfg_we ? cfg_data : exp_func_r;
    byte_idx_nxt  = byte_idx_r;
    crc_nxt       = crc_r;
    func_seen_nxt = func_seen_r;
    data_nxt      = data_r;
    crc_lo_nxt    = crc_lo_r;
    temp_nxt      = temp_r;
    humi_nxt      = humi_r;
    last_ok_nxt   = last_ok_r;
    status        = msrc_pkg::ST_OK;
    res_valid     = 1'b0;
    if (acc) begin
      if (func) begin
        // timeout aborts the frame
        last_ok_nxt = 1'b0;
        status      = msrc_pkg::ST_TIMEOUT;
        res_valid   = 1'b1;
      end else if (byte_idx_r < msrc_pkg::FRAME_LAST) begin
        if (byte_idx_r < msrc_pkg::CRC_SPAN) crc_nxt = crc_step;
        if (byte_idx_r == msrc_pkg::IDX_FUNC) begin
          func_seen_nxt = rx_byte;
        end else if (byte_idx_r >= msrc_pkg::IDX_DATA_LO &&
                     byte_idx_r <= msrc_pkg::IDX_DATA_HI) begin
          data_nxt = {data_r[23:0], rx_byte};
        end else if (byte_idx_r == msrc_pkg::IDX_CRC_LO) begin
          crc_lo_nxt = rx_byte;
        end
        byte_idx_nxt = byte_idx_r + 4'd1;
      end else begin
        // ninth word: CRC high byte
        res_valid = 1'b1;
        if (func_seen_r != exp_func_r) begin
          last_ok_nxt = 1'b0;
          status      = msrc_pkg::ST_TIMEOUT;
        end else if ({rx_byte, crc_lo_r} != crc_r) begin
          last_ok_nxt = 1'b0;
          status      = msrc_pkg::ST_CRC;
        end else begin
          temp_nxt    = data_r[31:16];
          humi_nxt    = data_r[15:0];
          last_ok_nxt = 1'b1;
          status      = msrc_pkg::ST_OK;
        end
      end
      // any result restarts the frame
      if (res_valid) begin
        byte_idx_nxt  = 4'd0;
        crc_nxt       = msrc_pkg::CRC_INIT;
        func_seen_nxt = 8'h00;
        data_nxt      = 32'h0;
        crc_lo_nxt    = 8'h00;
      end
    end
  end

  // Result carries the reading after this word's update
  always_comb begin
    res.status            = status;
    res.reading_valid     = last_ok_nxt;
    res.temperature_centi = temp_nxt;
    res.humidity_centi    = humi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_func_r  <= msrc_pkg::FUNC_RESET;
      byte_idx_r  <= 4'd0;
      crc_r       <= msrc_pkg::CRC_INIT;
      func_seen_r <= 8'h00;
      data_r      <= 32'h0;
      crc_lo_r    <= 8'h00;
      temp_r      <= 16'h0;
      humi_r      <= 16'h0;
      last_ok_r   <= 1'b0;
    end else begin
      exp_func_r  <= exp_func_nxt;
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      func_seen_r <= func_seen_nxt;
      data_r      <= data_nxt;
      crc_lo_r    <= crc_lo_nxt;
      temp_r      <= temp_nxt;
      humi_r      <= humi_nxt;
      last_ok_r   <= last_ok_nxt;
    end
  end

endmodule

@@ rtl/core/modbus_sensor_response_checker.sv @@
// Checks a 9-byte Modbus RTU read-input-registers response fed one received
// byte per word (in_func = 0), or aborts on a receive timeout word
// (in_func = 1). CRC-16/Modbus runs over bytes 0..6 and is compared with
// the little-endian CRC in bytes 7..8; the function code in byte 1 must
// match cfg_expected_function (reset 4). One word is taken every cycle
// while in_stall is low: the CRC byte update is a single unrolled XOR
// network in front of the frame state registers. A result word (ninth
// byte or timeout) is registered into the output register, or into the
// single skid word behind it while out_stall holds; in_stall rises only when
// both are full. Status 0 is ok (reading latched, reading_valid 1),
// 1 is timeout or wrong function code, 2 is CRC error; on failure the last
// reading is kept and reading_valid is 0. cfg_ready is always high.
module modbus_sensor_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_function,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_reading_valid,
  output logic [15:0] out_temperature_centi,
  output logic [15:0] out_humidity_centi
);

  logic              in_acc;
  logic              res_valid;
  msrc_pkg::result_t res;
  logic              out_vld_r,  out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  msrc_pkg::result_t out_r,      out_nxt;
  msrc_pkg::result_t skid_r,     skid_nxt;
  logic              out_free;
  logic              push;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid & ~in_stall;

  msrc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_expected_function),
    .acc       (in_acc),
    .func      (in_func),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with one skid word behind it
  assign out_free = ~out_vld_r | ~out_stall;
  assign push     = in_acc & res_valid;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r | push;
      out_nxt      = skid_vld_r ? skid_r : res;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid             = out_vld_r;
  assign out_status            = out_r.status;
  assign out_reading_valid     = out_r.reading_valid;
  assign out_temperature_centi = out_r.temperature_centi;
  assign out_humidity_centi    = out_r.humidity_centi;

endmodule

@@ rtl/core/msrc_checker.sv @@
module msrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_reading_valid,
  input logic [15:0] out_temperature_centi,
  input logic [15:0] out_humidity_centi
);

  // only the three defined status codes leave the block
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == msrc_pkg::ST_OK ||
                   out_status == msrc_pkg::ST_TIMEOUT ||
                   out_status == msrc_pkg::ST_CRC))
    else $error("illegal status code");

  // a good frame always marks the reading valid
  a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == msrc_pkg::ST_OK) |-> out_reading_valid)
    else $error("ok status without valid reading");

  // any failure marks the reading invalid
  a_fail_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != msrc_pkg::ST_OK) |-> !out_reading_valid)
    else $error("failure status with valid reading");

  // stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_reading_valid) && $stable(out_temperature_centi) &&
      $stable(out_humidity_centi)))
    else $error("stalled result word changed");

endmodule

bind modbus_sensor_response_checker msrc_checker u_msrc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_status            (out_status),
  .out_reading_valid     (out_reading_valid),
  .out_temperature_centi (out_temperature_centi),
  .out_humidity_centi    (out_humidity_centi)
);

@@ bench/tb_modbus_sensor_response_checker.sv @@
module tb_modbus_sensor_response_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  // How a directed row picks the byte it sends
  typedef enum logic [2:0] {
    ROW_BYTE,
    ROW_TIMEOUT,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_HI_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [7:0]        value;
    logic              typed;
    msrc_pkg::result_t preset;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_expected_function = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_reading_valid;
  logic [15:0] out_temperature_centi;
  logic [15:0] out_humidity_centi;

  modbus_sensor_response_checker dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_expected_function (cfg_expected_function),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_func               (in_func),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_reading_valid     (out_reading_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Frame tracker state, mirrors the block
  logic [7:0]  want_func = msrc_pkg::FUNC_RESET;
  logic [3:0]  frame_pos = 4'd0;
  logic [15:0] crc_acc = msrc_pkg::CRC_INIT;
  logic [7:0]  func_got = 8'h00;
  logic [31:0] payload_acc = 32'h0;
  logic [7:0]  crc_lo_got = 8'h00;
  logic [15:0] held_temp = 16'h0;
  logic [15:0] held_humi = 16'h0;
  logic        held_fresh = 1'b0;

  msrc_pkg::result_t pending_reports [$];
  msrc_pkg::result_t got_report;
  msrc_pkg::result_t want_report;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int words_sent = 0;
  int reports_seen = 0;
  int n_good = 0;
  int n_crc_bad = 0;
  int n_rejected = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int hold_events = 0;
  logic hold_req = 1'b0;

  // Directed frames: timeout from reset, wrong function (with bad CRC too,
  // so the function check must win), a clean frame at the data extremes,
  // a timeout part way into a frame, and a CRC failure
  stim_row_t directed_rows [30] = '{
    '{ROW_TIMEOUT,    8'h00, 1'b1, '{msrc_pkg::ST_TIMEOUT, 1'b0, 16'h0000, 16'h0000}},
    '{ROW_BYTE,       8'hFF, 1'b0, '0},
    '{ROW_BYTE,       8'h03, 1'b0, '0},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_BYTE,       8'h12, 1'b0, '0},
    '{ROW_BYTE,       8'h34, 1'b0, '0},
    '{ROW_BYTE,       8'h56, 1'b0, '0},
    '{ROW_BYTE,       8'h78, 1'b0, '0},
    '{ROW_CRC_LO,     8'h00, 1'b0, '0},
    '{ROW_CRC_HI_BAD, 8'h00, 1'b1, '{msrc_pkg::ST_TIMEOUT, 1'b0, 16'h0000, 16'h0000}},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_BYTE,       8'h04, 1'b0, '0},
    '{ROW_BYTE,       8'h04, 1'b0, '0},
    '{ROW_BYTE,       8'hFF, 1'b0, '0},
    '{ROW_BYTE,       8'hFF, 1'b0, '0},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_CRC_LO,     8'h00, 1'b0, '0},
    '{ROW_CRC_HI,     8'h00, 1'b1, '{msrc_pkg::ST_OK, 1'b1, 16'hFFFF, 16'h0000}},
    '{ROW_BYTE,       8'h01, 1'b0, '0},
    '{ROW_TIMEOUT,    8'hFF, 1'b1, '{msrc_pkg::ST_TIMEOUT, 1'b0, 16'hFFFF, 16'h0000}},
    '{ROW_BYTE,       8'h01, 1'b0, '0},
    '{ROW_BYTE,       8'h04, 1'b0, '0},
    '{ROW_BYTE,       8'h04, 1'b0, '0},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_BYTE,       8'h00, 1'b0, '0},
    '{ROW_BYTE,       8'hFF, 1'b0, '0},
    '{ROW_BYTE,       8'hFF, 1'b0, '0},
    '{ROW_CRC_LO,     8'h00, 1'b0, '0},
    '{ROW_CRC_HI_BAD, 8'h00, 1'b1, '{msrc_pkg::ST_CRC, 1'b0, 16'hFFFF, 16'h0000}}
  };

  // CRC-16/Modbus, one data bit fed per step
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[15:1]} ^ (fb ? msrc_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic restart_frame();
    frame_pos = 4'd0;
    crc_acc = msrc_pkg::CRC_INIT;
    func_got = 8'h00;
    payload_acc = 32'h0;
    crc_lo_got = 8'h00;
  endtask

  // Advance the tracker by one accepted word; a report on timeout or ninth byte
  task automatic track_word(input logic f, input logic [7:0] b,
                            output logic produced, output msrc_pkg::result_t rep);
    logic [1:0] st;
    produced = 1'b0;
    rep = '0;
    if (f) begin
      held_fresh = 1'b0;
      restart_frame();
      produced = 1'b1;
      rep = '{msrc_pkg::ST_TIMEOUT, held_fresh, held_temp, held_humi};
    end else if (frame_pos < msrc_pkg::FRAME_LAST) begin
      if (frame_pos < msrc_pkg::CRC_SPAN)
        crc_acc = crc16_step(crc_acc, b);
      if (frame_pos == msrc_pkg::IDX_FUNC)
        func_got = b;
      else if (frame_pos >= msrc_pkg::IDX_DATA_LO && frame_pos <= msrc_pkg::IDX_DATA_HI)
        payload_acc = {payload_acc[23:0], b};
      else if (frame_pos == msrc_pkg::IDX_CRC_LO)
        crc_lo_got = b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      // function code is checked ahead of the CRC
      if (func_got != want_func) begin
        held_fresh = 1'b0;
        st = msrc_pkg::ST_TIMEOUT;
      end else if ({b, crc_lo_got} != crc_acc) begin
        held_fresh = 1'b0;
        st = msrc_pkg::ST_CRC;
      end else begin
        held_temp = payload_acc[31:16];
        held_humi = payload_acc[15:0];
        held_fresh = 1'b1;
        st = msrc_pkg::ST_OK;
      end
      restart_frame();
      produced = 1'b1;
      rep = '{st, held_fresh, held_temp, held_humi};
    end
  endtask

  // Offer one word, hold it until taken, then queue what it should produce
  task automatic send_word(input logic f, input logic [7:0] b,
                           input logic typed, input msrc_pkg::result_t preset);
    logic              produced;
    msrc_pkg::result_t rep;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    track_word(f, b, produced, rep);
    if (produced)
      pending_reports.push_back(typed ? preset : rep);
    @(negedge clk);
  endtask

  // Wait for every queued report, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_function(input logic [7:0] code);
    cfg_valid <= 1'b1;
    cfg_expected_function <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    want_func = code;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames; some corrupted, some cut short by a timeout
  task automatic send_random_frame();
    logic [7:0]  fr [9];
    logic [15:0] c;
    int          cut;
    if (frame_pos != 4'd0 && $urandom_range(1) == 0)
      send_word(1'b1, 8'($urandom_range(255)), 1'b0, '0);
    fr[0] = 8'($urandom_range(255));
    fr[1] = ($urandom_range(99) < 85) ? want_func : 8'($urandom_range(255));
    fr[2] = ($urandom_range(99) < 90) ? 8'h04 : 8'($urandom_range(255));
    for (int k = 3; k < 7; k++) begin
      case ($urandom_range(5))
        0: fr[k] = 8'h00;
        1: fr[k] = 8'hFF;
        default: fr[k] = 8'($urandom_range(255));
      endcase
    end
    c = msrc_pkg::CRC_INIT;
    for (int k = 0; k < 7; k++) c = crc16_step(c, fr[k]);
    fr[7] = c[7:0];
    fr[8] = c[15:8];
    if ($urandom_range(99) < 12)
      fr[$urandom_range(8)] ^= 8'(1 << $urandom_range(7));
    cut = ($urandom_range(99) < 8) ? $urandom_range(8) : 9;
    for (int k = 0; k < cut; k++) send_word(1'b0, fr[k], 1'b0, '0);
    if (cut < 9)
      send_word(1'b1, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic run_phase(input int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        // stray words and stray timeouts
        repeat ($urandom_range(1, 4))
          send_word($urandom_range(99) < 25, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        send_random_frame();
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0] row_byte;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct = 18;
    recv_gap_pct = 57;
    for (int r = 0; r < $size(directed_rows); r++) begin
      case (directed_rows[r].kind)
        ROW_CRC_LO:     row_byte = crc_acc[7:0];
        ROW_CRC_HI:     row_byte = crc_acc[15:8];
        ROW_CRC_HI_BAD: row_byte = ~crc_acc[15:8];
        default:        row_byte = directed_rows[r].value;
      endcase
      send_word(directed_rows[r].kind == ROW_TIMEOUT, row_byte,
                directed_rows[r].typed, directed_rows[r].preset);
    end

    settle();
    write_function(8'h00);
    run_phase(520);

    settle();
    send_gap_pct = 57;
    recv_gap_pct = 18;
    write_function(8'hFF);
    run_phase(260);
    // sender pauses until the block has drained
    settle();
    run_phase(260);

    settle();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_function(8'($urandom_range(255)));
    // long output hold-off while words keep coming
    hold_req = 1'b1;
    run_phase(530);

    settle();
    $display("drove %0d words, checked %0d reports: %0d good readings,",
             words_sent, reports_seen, n_good);
    $display("%0d crc failures, %0d rejects; function codes 04, 00, ff and %02h; %0d hold-off(s)",
             n_crc_bad, n_rejected, want_func, hold_events);
    if (error_count == 0)
      $display("tb_modbus_sensor_response_checker: clean");
    else
      $display("tb_modbus_sensor_response_checker: errors");
    $finish;
  end

  // Result side stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
      hold_events++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Compare each taken report with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_report = '{out_status, out_reading_valid, out_temperature_centi,
                     out_humidity_centi};
      reports_seen++;
      case (got_report.status)
        msrc_pkg::ST_OK:  n_good++;
        msrc_pkg::ST_CRC: n_crc_bad++;
        default:          n_rejected++;
      endcase
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: unexpected report st %0d rv %0b t %04h h %04h", $time,
                 got_report.status, got_report.reading_valid,
                 got_report.temperature_centi, got_report.humidity_centi);
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report !== want_report) begin
          error_count++;
          $display("%0t: mismatch expected st %0d rv %0b t %04h h %04h,",
                   $time, want_report.status, want_report.reading_valid,
                   want_report.temperature_centi, want_report.humidity_centi);
          $display("%0t:          got st %0d rv %0b t %04h h %04h",
                   $time, got_report.status, got_report.reading_valid,
                   got_report.temperature_centi, got_report.humidity_centi);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d reports outstanding", $time,
               QUIET_LIMIT, pending_reports.size());
      $display("tb_modbus_sensor_response_checker: errors");
      $finish;
    end
  end

endmodule

@@ sim.f @@
rtl/core/msrc_pkg.sv
rtl/core/msrc_frame.sv
rtl/core/modbus_sensor_response_checker.sv
rtl/core/msrc_checker.sv
bench/tb_modbus_sensor_response_checker.sv
